FILE: sv/bctu_pkg.sv
// Shared types and constants for the BLDC commutation timing update unit.
`default_nettype none

package bctu_pkg;

  // Field widths
  localparam int unsigned ZC_W     = 16;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned ERR_W    = 17;
  localparam int unsigned SPEED_W  = 32;
  localparam int unsigned GAIN_W   = 8;
  localparam int unsigned STALL_W  = 16;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 136;

  // Arithmetic widths
  localparam int unsigned PROD_W = 25;  // signed error times 8-bit gain
  localparam int unsigned FACC_W = 41;  // two weighted 32-bit speeds
  localparam int unsigned DREM_W = 16;  // divider remainder, divisor is at most 16 bits
  localparam int unsigned CNT_W  = 6;

  // Step counts of the serial units
  localparam int unsigned MUL_STEPS    = GAIN_W;
  localparam int unsigned DIV_SPD_STEPS = SPEED_W;
  localparam int unsigned DIV_FLT_STEPS = FACC_W;

  // Constants of the control law
  localparam logic [PERIOD_W-1:0] PERIOD_MAX  = 16'hFFFF;
  localparam logic [STALL_W-1:0]  STALL_MAX   = 16'hFFFF;
  localparam logic [STALL_W-1:0]  STALL_LIMIT = 16'd2;
  localparam logic [STALL_W-1:0]  STALL_DROP  = 16'd3;
  localparam logic [3:0]          MARGIN_UNIT = 4'd10;
  localparam logic [4:0]          GAIN_ROUND  = 5'd31;   // gain scale is 1/32

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECEL_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_CONST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_NEW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_OLD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_MARGIN = 3'd6;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CORR,
    ST_DIV_SPD,
    ST_FILT,
    ST_DIV_FLT,
    ST_WRITE
  } state_t;

endpackage

`default_nettype wire

FILE: sv/bldc_commutation_timing_update_unit.sv
// Top level: sensorless BLDC commutation period correction, speed and stall logic.
// One item in flight: the next beat is taken once the result sits in the output
//   register (it may still wait there for the sink).
// The work is set by the shared bit-serial divider (32 + 41 steps, the second divide
//   skipped when both filter weights are 0) and two 8-step shift-add multipliers.
// Reset (rst, synchronous): registers to defaults, period 65535, speed filter and stall 0.
`default_nettype none

module bldc_commutation_timing_update_unit
  import bctu_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // [15:0] zc_time, [16] is_running
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0]      m_axis_tdata,   // [15:0] match_time, [31:16] next_period,
                                                    // [48:32] crossing_error, [80:49] speed,
                                                    // [112:81] filtered_speed,
                                                    // [128:113] stall_level, [129] stop
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // Configuration registers
  logic [GAIN_W-1:0]  decel_gain;
  logic [GAIN_W-1:0]  accel_gain;
  logic [SPEED_W-1:0] speed_constant;
  logic [GAIN_W-1:0]  filter_weight_new;
  logic [GAIN_W-1:0]  filter_weight_old;
  logic [SPEED_W-1:0] max_speed;
  logic [GAIN_W-1:0]  stall_margin;

  // Controller state carried across events
  logic [PERIOD_W-1:0] period;
  logic [SPEED_W-1:0]  smoothed_speed;
  logic [STALL_W-1:0]  stall_counter;

  // Sequencer
  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             in_fire;
  logic             out_load;
  logic             last_step;

  // Per-item working registers
  logic [ERR_W-1:0]    err;
  logic                running;
  logic [PERIOD_W-1:0] match;
  logic [GAIN_W-1:0]   gain_sr;
  logic [PROD_W-1:0]   prod;
  logic [PERIOD_W-1:0] np;
  logic [SPEED_W-1:0]  spd;
  logic [GAIN_W-1:0]   wa_sr;
  logic [GAIN_W-1:0]   wb_sr;
  logic [FACC_W-1:0]   facc;
  logic [SPEED_W-1:0]  filt;

  // Shared restoring divider
  logic [DREM_W-1:0]   div_rem;
  logic [FACC_W-1:0]   div_dq;       // dividend shifts out the top, quotient in the bottom
  logic [DREM_W-1:0]   div_den;
  logic [DREM_W+1:0]   div_trial;
  logic [DREM_W-1:0]   div_rem_next;
  logic [FACC_W-1:0]   div_dq_next;

  // Combinational helpers
  logic [ERR_W-1:0]    err_in;
  logic [PROD_W-1:0]   prod_next;
  logic [PROD_W-1:0]   prod_adj;
  logic [PROD_W-1:0]   corr;
  logic [PROD_W-1:0]   np_sum;
  logic [PERIOD_W-1:0] np_clamped;
  logic [FACC_W-1:0]   facc_next;
  logic [GAIN_W:0]     wsum;
  logic [SPEED_W:0]    limit;
  logic                over;
  logic [STALL_W-1:0]  stall_upd;
  logic                stop;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign last_step = (cnt == '0);

  // Error against half the period in force
  assign err_in = {1'b0, s_axis_tdata[ZC_W-1:0]} - {2'b00, period[PERIOD_W-1:1]};

  // Shift-add multiply of the error by the gain, MSB of the gain first
  assign prod_next = {prod[PROD_W-2:0], 1'b0}
                   + (gain_sr[GAIN_W-1] ? {{(PROD_W-ERR_W){err[ERR_W-1]}}, err} : '0);

  // Divide by 32 truncating toward zero, add to period, clamp to 1..65535
  assign prod_adj = prod[PROD_W-1] ? (prod + PROD_W'(GAIN_ROUND)) : prod;
  assign corr     = {{5{prod_adj[PROD_W-1]}}, prod_adj[PROD_W-1:5]};
  assign np_sum   = {{(PROD_W-PERIOD_W){1'b0}}, period} + corr;

  always_comb begin
    if (np_sum[PROD_W-1] || (np_sum == '0)) begin
      np_clamped = PERIOD_W'(1);
    end else if (|np_sum[PROD_W-2:PERIOD_W]) begin
      np_clamped = PERIOD_MAX;
    end else begin
      np_clamped = np_sum[PERIOD_W-1:0];
    end
  end

  // One restoring divide step
  assign div_trial = {1'b0, div_rem, div_dq[FACC_W-1]} - {2'b00, div_den};
  always_comb begin
    if (!div_trial[DREM_W+1]) begin
      div_rem_next = div_trial[DREM_W-1:0];
      div_dq_next  = {div_dq[FACC_W-2:0], 1'b1};
    end else begin
      div_rem_next = {div_rem[DREM_W-2:0], div_dq[FACC_W-1]};
      div_dq_next  = {div_dq[FACC_W-2:0], 1'b0};
    end
  end

  // Serial weighted sum A*speed + B*old, weight MSB first
  assign facc_next = {facc[FACC_W-2:0], 1'b0}
                   + (wa_sr[GAIN_W-1] ? {{(FACC_W-SPEED_W){1'b0}}, spd} : '0)
                   + (wb_sr[GAIN_W-1] ? {{(FACC_W-SPEED_W){1'b0}}, smoothed_speed} : '0);
  assign wsum = {1'b0, filter_weight_new} + {1'b0, filter_weight_old};

  // Stall counter update and stop decision
  assign limit = {1'b0, max_speed} + ((SPEED_W+1)'(stall_margin) * (SPEED_W+1)'(MARGIN_UNIT));
  assign over  = ({1'b0, filt} > limit);

  always_comb begin
    if (over) begin
      stall_upd = (stall_counter != STALL_MAX) ? stall_counter + 1'b1 : stall_counter;
    end else begin
      stall_upd = (stall_counter > STALL_DROP) ? stall_counter - STALL_DROP : '0;
    end
  end
  assign stop = (stall_upd > STALL_LIMIT) && running;

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_fire) state_next = ST_MUL;
      ST_MUL:     if (last_step) state_next = ST_CORR;
      ST_CORR:    state_next = ST_DIV_SPD;
      ST_DIV_SPD: if (last_step) state_next = ST_FILT;
      ST_FILT: begin
        if (last_step) state_next = (wsum == '0) ? ST_WRITE : ST_DIV_FLT;
      end
      ST_DIV_FLT: if (last_step) state_next = ST_WRITE;
      ST_WRITE:   if (out_load) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_WRITE: out_load      = !m_axis_tvalid || m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
      end
    endcase
  end

  // Control registers: state, configuration, controller state, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      decel_gain        <= 8'd8;
      accel_gain        <= 8'd8;
      speed_constant    <= '0;
      filter_weight_new <= 8'd1;
      filter_weight_old <= 8'd3;
      max_speed         <= '0;
      stall_margin      <= '0;
      period            <= PERIOD_MAX;
      smoothed_speed    <= '0;
      stall_counter     <= '0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_DECEL_GAIN:   decel_gain        <= cfg_data[GAIN_W-1:0];
          REG_ACCEL_GAIN:   accel_gain        <= cfg_data[GAIN_W-1:0];
          REG_SPEED_CONST:  speed_constant    <= cfg_data[SPEED_W-1:0];
          REG_WEIGHT_NEW:   filter_weight_new <= cfg_data[GAIN_W-1:0];
          REG_WEIGHT_OLD:   filter_weight_old <= cfg_data[GAIN_W-1:0];
          REG_MAX_SPEED:    max_speed         <= cfg_data[SPEED_W-1:0];
          REG_STALL_MARGIN: stall_margin      <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        period         <= stop ? PERIOD_MAX : np;
        smoothed_speed <= filt;
        stall_counter  <= stop ? '0 : stall_upd;
        m_axis_tvalid  <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid  <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        err     <= err_in;
        running <= s_axis_tdata[ZC_W];
        match   <= period;
        gain_sr <= err_in[ERR_W-1] ? accel_gain : decel_gain;
        prod    <= '0;
        cnt     <= CNT_W'(MUL_STEPS - 1);
      end
      ST_MUL: begin
        prod    <= prod_next;
        gain_sr <= {gain_sr[GAIN_W-2:0], 1'b0};
        cnt     <= cnt - 1'b1;
      end
      ST_CORR: begin
        np      <= np_clamped;
        div_den <= np_clamped;
        div_rem <= '0;
        div_dq  <= {speed_constant, {(FACC_W-SPEED_W){1'b0}}};
        cnt     <= CNT_W'(DIV_SPD_STEPS - 1);
      end
      ST_DIV_SPD: begin
        div_rem <= div_rem_next;
        div_dq  <= div_dq_next;
        if (last_step) begin
          spd   <= div_dq_next[SPEED_W-1:0];
          wa_sr <= filter_weight_new;
          wb_sr <= filter_weight_old;
          facc  <= '0;
          cnt   <= CNT_W'(MUL_STEPS - 1);
        end else begin
          cnt   <= cnt - 1'b1;
        end
      end
      ST_FILT: begin
        facc  <= facc_next;
        wa_sr <= {wa_sr[GAIN_W-2:0], 1'b0};
        wb_sr <= {wb_sr[GAIN_W-2:0], 1'b0};
        if (last_step) begin
          // both weights zero: the filter holds its value
          filt    <= smoothed_speed;
          div_dq  <= facc_next;
          div_rem <= '0;
          div_den <= {{(DREM_W-GAIN_W-1){1'b0}}, wsum};
          cnt     <= CNT_W'(DIV_FLT_STEPS - 1);
        end else begin
          cnt     <= cnt - 1'b1;
        end
      end
      ST_DIV_FLT: begin
        div_rem <= div_rem_next;
        div_dq  <= div_dq_next;
        cnt     <= cnt - 1'b1;
        if (last_step) filt <= div_dq_next[SPEED_W-1:0];
      end
      ST_WRITE: begin
        if (out_load) begin
          m_axis_tdata <= {6'b0, stop,
                           stop ? {STALL_W{1'b0}} : stall_upd,
                           filt, spd, err,
                           stop ? PERIOD_MAX : np,
                           match};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/bctu_checker.sv
// Port-level checker for the commutation timing unit, bound to the top level.
`default_nettype none

module bctu_checker
  import bctu_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

  // A held result beat must stay valid and unchanged
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  // Only one item in flight: after an input beat the input side closes
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // A result never appears in the cycle right after an input beat
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

  // A stop forces the maximum period and clears the stall level
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[129] |->
      (m_axis_tdata[31:16] == PERIOD_MAX) && (m_axis_tdata[128:113] == '0))
    else $error("stop without period reset or stall clear");

  // Periods reported are never zero
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[15:0] != '0) && (m_axis_tdata[31:16] != '0))
    else $error("zero commutation period reported");

endmodule

bind bldc_commutation_timing_update_unit bctu_checker u_bctu_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
